>>> rtl/detector_raw_bank_hit_parser_defines.svh
// Assertion macros shared by the raw bank parser modules.
`ifndef DETECTOR_RAW_BANK_HIT_PARSER_DEFINES_SVH
`define DETECTOR_RAW_BANK_HIT_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DRBHP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DRBHP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/drbhp_pkg.sv
// Types, constants and lookup for the raw bank hit parser.
`timescale 1ns / 1ps
package drbhp_pkg;

	localparam int MAX_BANK_WORDS = 1024;
	localparam int LEN_W = 11;
	localparam int HITS_W = 11;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	localparam logic [12:0] TABLE_ENTRIES_RST = 13'd4096;
	localparam logic [3:0] SOURCE_LIMIT_RST = 4'd10;
	localparam logic [15:0] N_SOURCES = 16'd10;
	localparam logic [LEN_W-1:0] MIN_BANK_WORDS = LEN_W'(6);

	localparam logic CFG_TABLE_ENTRIES = 1'b0;
	localparam logic CFG_SOURCE_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_COUNT,
		PH_DATA,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HIT,
		KIND_DROP,
		KIND_DONE,
		KIND_ERROR
	} kind_t;

	typedef enum logic [1:0] {
		ERR_SHORT,
		ERR_PADDING,
		ERR_HITS,
		ERR_SOURCE
	} err_t;

	typedef struct packed {
		kind_t kind;
		err_t error_code;
		logic [11:0] address;
		logic [3:0] tdc;
		logic [1:0] station;
		logic [1:0] section;
		logic last;
	} result_t;

	// all results caused by one word
	typedef struct packed {
		logic two;
		result_t r0;
		result_t r1;
	} entry_t;

	function automatic logic [1:0] station_of(input logic [3:0] src);
		logic [1:0] stn;
		case (src)
			4'd4, 4'd5: stn = 2'd1;
			4'd6, 4'd7: stn = 2'd2;
			4'd8, 4'd9: stn = 2'd3;
			default: stn = 2'd0;
		endcase
		return stn;
	endfunction

endpackage

>>> rtl/drbhp_front.sv
// Front end: word parser state, config registers, builds per-word result entries.
`timescale 1ns / 1ps
`include "detector_raw_bank_hit_parser_defines.svh"
module drbhp_front
	import drbhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        push,
	input  logic [15:0] word,
	input  logic        first,
	input  logic [10:0] bank_words,
	input  logic [15:0] source_id,
	input  logic        full,
	output logic        wr,
	output entry_t      wr_entry
);

	logic [12:0] tab_q;
	logic [3:0] src_limit_q;

	phase_t phase_q, phase_d, ph;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [LEN_W-1:0] pre_q, pre_d;
	logic [2:0] sec_q, sec_d, sec;
	logic [HITS_W-1:0] hits_q, hits_d, hits;
	logic [1:0] station_q, station_d;

	logic acc;
	logic [LEN_W-1:0] len_c;
	logic [16:0] pre_c;
	logic src_bad;
	logic [1:0] stn_new;
	logic [LEN_W-1:0] remaining;
	logic count_err;
	logic has_a, has_b;
	result_t res_a, res_b;

	assign acc = push && !full;

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		length_d = length_q;
		pre_d = pre_q;
		sec_d = sec_q;
		hits_d = hits_q;
		station_d = station_q;
		ph = phase_q;
		sec = sec_q;
		hits = hits_q;
		count_err = 1'b0;
		has_a = 1'b0;
		has_b = 1'b0;
		res_a = '0;
		res_b = '0;

		len_c = (bank_words > LEN_W'(MAX_BANK_WORDS)) ? LEN_W'(MAX_BANK_WORDS) : bank_words;
		pre_c = ({1'b0, word} + 17'd3) & ~17'd1;
		src_bad = (source_id >= {12'd0, src_limit_q}) || (source_id >= N_SOURCES);
		stn_new = station_of(source_id[3:0]);
		remaining = length_q - idx_q;

		if (first) begin
			phase_d = PH_IDLE;
			has_a = 1'b1;
			res_a.kind = KIND_ERROR;
			if (src_bad) begin
				res_a.error_code = ERR_SOURCE;
			end else begin
				station_d = stn_new;
				res_a.station = stn_new;
				if (len_c < MIN_BANK_WORDS) begin
					res_a.error_code = ERR_SHORT;
				end else if (pre_c > {6'd0, len_c}) begin
					res_a.error_code = ERR_PADDING;
				end else begin
					has_a = 1'b0;
					phase_d = PH_PRE;
					length_d = len_c;
					pre_d = pre_c[LEN_W-1:0];
					idx_d = LEN_W'(1);
					sec_d = 3'd0;
					hits_d = '0;
				end
			end
		end else if (phase_q != PH_IDLE && idx_q < length_q) begin
			if (ph == PH_PRE && idx_q >= pre_q) begin
				ph = PH_COUNT;
			end
			if (ph == PH_COUNT) begin
				if (({1'b0, word} + 17'd1) > {6'd0, remaining}) begin
					has_a = 1'b1;
					count_err = 1'b1;
					res_a.kind = KIND_ERROR;
					res_a.error_code = ERR_HITS;
					res_a.station = station_q;
					ph = PH_IDLE;
				end else if (word == 16'd0) begin
					sec = sec + 3'd1;
					ph = (sec >= 3'd4) ? PH_TAIL : PH_COUNT;
				end else begin
					hits = word[HITS_W-1:0];
					ph = PH_DATA;
				end
			end else if (ph == PH_DATA) begin
				has_a = 1'b1;
				res_a.kind = ({1'b0, word[11:0]} < tab_q) ? KIND_HIT : KIND_DROP;
				res_a.address = word[11:0];
				res_a.tdc = word[15:12];
				res_a.station = station_q;
				res_a.section = sec[1:0];
				hits = hits - HITS_W'(1);
				if (hits == '0) begin
					sec = sec + 3'd1;
					ph = (sec >= 3'd4) ? PH_TAIL : PH_COUNT;
				end
			end
			if (!count_err && (({1'b0, idx_q} + 12'd1) >= {1'b0, length_q})) begin
				has_b = 1'b1;
				res_b.kind = (ph == PH_TAIL) ? KIND_DONE : KIND_ERROR;
				res_b.error_code = ERR_SHORT;
				res_b.station = station_q;
				ph = PH_IDLE;
			end
			phase_d = ph;
			sec_d = sec;
			hits_d = hits;
			idx_d = idx_q + LEN_W'(1);
		end

		res_a.last = !has_b;
		res_b.last = 1'b1;
		wr_entry.two = has_a && has_b;
		wr_entry.r0 = has_a ? res_a : res_b;
		wr_entry.r1 = res_b;
	end

	assign wr = acc && (has_a || has_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= TABLE_ENTRIES_RST;
			src_limit_q <= SOURCE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TABLE_ENTRIES: tab_q <= cfg_data;
				CFG_SOURCE_LIMIT: src_limit_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q <= '0;
			length_q <= '0;
			pre_q <= '0;
			sec_q <= '0;
			hits_q <= '0;
			station_q <= '0;
		end else if (acc) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			length_q <= length_d;
			pre_q <= pre_d;
			sec_q <= sec_d;
			hits_q <= hits_d;
			station_q <= station_d;
		end
	end

	`DRBHP_ASSERT_NXT(a_err_ends_bank, wr && (wr_entry.r0.kind == KIND_ERROR || (wr_entry.two && wr_entry.r1.kind == KIND_ERROR)), phase_q == PH_IDLE, "error beat did not end the bank")
	`DRBHP_ASSERT_IMP(a_data_has_hits, phase_q == PH_DATA, hits_q != '0, "data phase with no hits left")

endmodule

>>> rtl/drbhp_queue.sv
// Short queue of result entries between parser and result unpacker.
`timescale 1ns / 1ps
`include "detector_raw_bank_hit_parser_defines.svh"
module drbhp_queue
	import drbhp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   rd,
	output logic   q_empty,
	output entry_t head
);

	entry_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q, rptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign full = (cnt_q == Q_CW'(Q_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + Q_AW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + Q_AW'(1);
			end
			case ({wr, rd})
				2'b10: cnt_q <= cnt_q + Q_CW'(1);
				2'b01: cnt_q <= cnt_q - Q_CW'(1);
				default: ;
			endcase
		end
	end

	`DRBHP_ASSERT_IMP(a_no_overflow, wr, cnt_q < Q_CW'(Q_DEPTH), "write into a full queue")
	`DRBHP_ASSERT_IMP(a_no_underflow, rd, cnt_q != '0, "read from an empty queue")

endmodule

>>> rtl/drbhp_back.sv
// Back end: splits queued entries into single result beats.
`timescale 1ns / 1ps
`include "detector_raw_bank_hit_parser_defines.svh"
module drbhp_back
	import drbhp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  entry_t  head,
	input  logic    pop,
	output logic    rd,
	output result_t res
);

	logic sub_q;
	logic take;

	assign take = pop && !q_empty;
	assign rd = take && (!head.two || sub_q);
	assign res = sub_q ? head.r1 : head.r0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (take) begin
			sub_q <= head.two && !sub_q;
		end
	end

	`DRBHP_ASSERT_IMP(a_sub_on_pair, sub_q, !q_empty && head.two, "second beat without a paired entry")

endmodule

>>> rtl/detector_raw_bank_hit_parser.sv
// Raw readout bank hit parser, top level.
// Takes one 16-bit bank word per cycle while full is low and turns it into hit,
// dropped-hit, done and error results. The parser updates its bank state in the
// cycle a word is taken; words that cause results put one entry into a four-deep
// queue, and the result side pops it one beat at a time. Most words cause zero
// or one result; the last data word of a clean or short bank causes two, which
// take two result beats. Sustained input rate is one word per cycle as long as
// the consumer pops a result every cycle and two-result words are rare; full
// rises once four entries wait. Configuration is held in table_entries (index 0)
// and source_limit (index 1).
`timescale 1ns / 1ps
module detector_raw_bank_hit_parser
	import drbhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [15:0] word,
	input  logic        first,
	input  logic [10:0] bank_words,
	input  logic [15:0] source_id,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [1:0]  error_code,
	output logic [11:0] address,
	output logic [3:0]  tdc,
	output logic [1:0]  station,
	output logic [1:0]  section,
	output logic        last
);

	logic wr;
	entry_t wr_entry;
	logic rd;
	logic q_empty;
	entry_t head;
	result_t res;

	drbhp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.word       (word),
		.first      (first),
		.bank_words (bank_words),
		.source_id  (source_id),
		.full       (full),
		.wr         (wr),
		.wr_entry   (wr_entry)
	);

	drbhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_entry (wr_entry),
		.full     (full),
		.rd       (rd),
		.q_empty  (q_empty),
		.head     (head)
	);

	drbhp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.head    (head),
		.pop     (pop),
		.rd      (rd),
		.res     (res)
	);

	assign empty = q_empty;
	assign kind = res.kind;
	assign error_code = res.error_code;
	assign address = res.address;
	assign tdc = res.tdc;
	assign station = res.station;
	assign section = res.section;
	assign last = res.last;

endmodule

>>> test/detector_raw_bank_hit_parser_tb.sv
`timescale 1ns / 1ps
// Testbench for the raw bank hit parser: directed and random banks checked against a predictor.
import drbhp_pkg::*;

typedef struct {
	logic [15:0] value;
	logic        is_first;
	logic [10:0] length;
	logic [15:0] source;
} bank_word_t;

class hit_scoreboard;
	logic [1:0]  station_map [10] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3};
	logic [12:0] table_entries = 13'd4096;
	logic [3:0]  source_limit = 4'd10;
	phase_t      phase = PH_IDLE;
	logic [10:0] word_index = '0;
	logic [10:0] length_reg = '0;
	logic [10:0] preamble_end = '0;
	logic [2:0]  section_index = '0;
	logic [15:0] hits_left = '0;
	logic [1:0]  station_reg = '0;
	result_t     waiting [$];
	int unsigned failures = 0;

	function void configure(logic [12:0] entries, logic [3:0] limit);
		table_entries = entries;
		source_limit = limit;
	endfunction

	function int pending();
		return waiting.size();
	endfunction

	function result_t make_result(kind_t k, err_t e, logic [11:0] a, logic [3:0] t,
			logic [1:0] stn, logic [1:0] sec);
		result_t r;
		r.kind = k;
		r.error_code = e;
		r.address = a;
		r.tdc = t;
		r.station = stn;
		r.section = sec;
		r.last = 1'b0;
		return r;
	endfunction

	function void advance_section();
		section_index = section_index + 3'd1;
		phase = (section_index >= 3'd4) ? PH_TAIL : PH_COUNT;
	endfunction

	// predict the results of one accepted word and update the bank state
	function void note_word(bank_word_t b);
		int unsigned wv, len, pre, idx;
		result_t out [$];
		wv = 32'(b.value);
		if (b.is_first) begin
			len = 32'(b.length);
			pre = 2 * ((wv + 3) / 2);
			phase = PH_IDLE;
			if (len > MAX_BANK_WORDS)
				len = MAX_BANK_WORDS;
			if (b.source >= {12'd0, source_limit} || b.source >= 16'd10) begin
				out.push_back(make_result(KIND_ERROR, ERR_SOURCE, '0, '0, '0, '0));
			end else begin
				station_reg = station_map[b.source];
				if (len < 6) begin
					out.push_back(make_result(KIND_ERROR, ERR_SHORT, '0, '0, station_reg, '0));
				end else if (pre > len) begin
					out.push_back(make_result(KIND_ERROR, ERR_PADDING, '0, '0, station_reg, '0));
				end else begin
					phase = PH_PRE;
					length_reg = 11'(len);
					preamble_end = 11'(pre);
					word_index = 11'd1;
					section_index = '0;
					hits_left = '0;
				end
			end
		end else if (phase != PH_IDLE && word_index < length_reg) begin
			idx = 32'(word_index);
			if (phase == PH_PRE && idx >= 32'(preamble_end))
				phase = PH_COUNT;
			if (phase == PH_COUNT && wv + 1 > 32'(length_reg) - idx) begin
				out.push_back(make_result(KIND_ERROR, ERR_HITS, '0, '0, station_reg, '0));
				phase = PH_IDLE;
			end else begin
				if (phase == PH_COUNT) begin
					if (wv == 0) begin
						advance_section();
					end else begin
						hits_left = 16'(wv);
						phase = PH_DATA;
					end
				end else if (phase == PH_DATA) begin
					out.push_back(make_result(
						({1'b0, b.value[11:0]} < table_entries) ? KIND_HIT : KIND_DROP,
						ERR_SHORT, b.value[11:0], b.value[15:12], station_reg,
						section_index[1:0]));
					hits_left = hits_left - 16'd1;
					if (hits_left == '0)
						advance_section();
				end
				if (idx + 1 >= 32'(length_reg)) begin
					out.push_back(make_result((phase == PH_TAIL) ? KIND_DONE : KIND_ERROR,
						ERR_SHORT, '0, '0, station_reg, '0));
					phase = PH_IDLE;
				end
				word_index = 11'(idx + 1);
			end
		end
		if (out.size() > 0)
			out[out.size() - 1].last = 1'b1;
		foreach (out[i])
			waiting.push_back(out[i]);
	endfunction

	function void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function void check_beat(result_t got);
		result_t want;
		if (waiting.size() == 0) begin
			$error("result beat with nothing expected: kind %0d", got.kind);
			failures++;
			return;
		end
		want = waiting.pop_front();
		compare_field("kind", 32'(want.kind), 32'(got.kind));
		compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
		compare_field("address", 32'(want.address), 32'(got.address));
		compare_field("tdc", 32'(want.tdc), 32'(got.tdc));
		compare_field("station", 32'(want.station), 32'(got.station));
		compare_field("section", 32'(want.section), 32'(got.section));
		compare_field("last", 32'(want.last), 32'(got.last));
	endfunction

	function void report_leftover();
		if (waiting.size() > 0) begin
			$error("%0d expected results never arrived", waiting.size());
			failures++;
		end
	endfunction
endclass

module detector_raw_bank_hit_parser_tb;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;
	logic        push;
	logic        full;
	logic [15:0] word;
	logic        first;
	logic [10:0] bank_words;
	logic [15:0] source_id;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [1:0]  error_code;
	logic [11:0] address;
	logic [3:0]  tdc;
	logic [1:0]  station;
	logic [1:0]  section;
	logic        last;

	hit_scoreboard sb;
	int unsigned   cycle_count = 0;
	int unsigned   items_sent = 0;
	int unsigned   beats = 0;
	int unsigned   rx_gap = 0;
	int unsigned   rx_hold = 0;
	bit            rx_burst = 1'b0;
	bit            tx_burst = 1'b0;
	logic [12:0]   cur_entries = 13'd4096;
	logic [3:0]    cur_limit = 4'd10;

	detector_raw_bank_hit_parser uut (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random pop gaps, two long hold-offs to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				sb.check_beat(result_t'{kind_t'(kind), err_t'(error_code), address, tdc,
					station, section, last});
				beats++;
				if ($urandom_range(0, 99) == 0)
					rx_burst = !rx_burst;
				if (beats == 150 || beats == 900)
					rx_hold = 300;
				else
					rx_gap = rx_burst ? 0 : pick_gap();
			end
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic bank_word_t make_word(logic [15:0] v, logic f, logic [10:0] len,
			logic [15:0] src);
		bank_word_t x;
		x.value = v;
		x.is_first = f;
		x.length = len;
		x.source = src;
		return x;
	endfunction

	function automatic bank_word_t filler();
		return make_word(16'($urandom), 1'b0, 11'($urandom), 16'($urandom));
	endfunction

	// data word, half of them with an address right at the table edge
	function automatic bank_word_t data_word();
		bank_word_t x;
		int e;
		x = filler();
		if ($urandom_range(0, 1)) begin
			e = int'(cur_entries) + $urandom_range(0, 3) - 2;
			if (e < 0)
				e = 0;
			if (e > 4095)
				e = 4095;
			x.value[11:0] = 12'(e);
		end
		return x;
	endfunction

	function automatic void build_bank(output bank_word_t b [$], output int unsigned count_at [$]);
		int unsigned pre_w, pre, total, trail, lim;
		int unsigned counts [4];
		bank_word_t x;
		b.delete();
		count_at.delete();
		pre_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 3);
		pre = 2 * ((pre_w + 3) / 2);
		total = pre + 4;
		foreach (counts[i]) begin
			counts[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			total += counts[i];
		end
		trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
		total += trail;
		lim = (cur_limit > 4'd10) ? 10 : 32'(cur_limit);
		x = filler();
		x.value = 16'(pre_w);
		x.is_first = 1'b1;
		x.length = 11'(total);
		x.source = 16'((lim == 0) ? $urandom : $urandom_range(0, lim - 1));
		b.push_back(x);
		for (int n = 1; n < pre; n++)
			b.push_back(filler());
		foreach (counts[i]) begin
			count_at.push_back(b.size());
			x = filler();
			x.value = 16'(counts[i]);
			b.push_back(x);
			repeat (counts[i])
				b.push_back(data_word());
		end
		repeat (trail)
			b.push_back(filler());
	endfunction

	task automatic send_word(bank_word_t b);
		int unsigned gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		word <= b.value;
		first <= b.is_first;
		bank_words <= b.length;
		source_id <= b.source;
		do @(posedge clk); while (full);
		sb.note_word(b);
		items_sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_config(logic [12:0] entries, logic [3:0] limit);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TABLE_ENTRIES;
		cfg_data <= entries;
		@(posedge clk);
		cfg_index <= CFG_SOURCE_LIMIT;
		cfg_data <= {9'd0, limit};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(entries, limit);
		cur_entries = entries;
		cur_limit = limit;
	endtask

	task automatic run_random(int unsigned quota);
		bank_word_t  b [$];
		int unsigned count_at [$];
		int unsigned start, k, pick, n;
		start = items_sent;
		while (items_sent - start < quota) begin
			build_bank(b, count_at);
			tx_burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// clean bank
			end else if (pick < 70) begin
				b[0].length = 11'($urandom_range(6, b.size() - 1));
			end else if (pick < 78) begin
				k = count_at[$urandom_range(0, 3)];
				b[k].value = $urandom_range(0, 1) ? 16'($urandom) :
					16'(b[k].value + $urandom_range(1, 8));
			end else if (pick < 86) begin
				// cut short, the next first word restarts
				k = $urandom_range(1, b.size() - 1);
				b = b[0:k-1];
				if ($urandom_range(0, 1))
					b[0].length = 11'($urandom_range(1025, 2047));
			end else if (pick < 93) begin
				case ($urandom_range(0, 2))
					0: b[0].source = 16'($urandom_range(0, 1) ?
						$urandom_range(32'(cur_limit), 15) : $urandom);
					1: b[0].length = 11'($urandom_range(0, 5));
					default: b[0].value = 16'($urandom_range(32'(b[0].length), 65535));
				endcase
				b = b[0:$urandom_range(0, 2)];
			end else begin
				n = $urandom_range(1, 3);
				repeat (n)
					send_word(filler());
				items_sent -= n;
				continue;
			end
			foreach (b[i])
				send_word(b[i]);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		push = 1'b0;
		word = '0;
		first = 1'b0;
		bank_words = '0;
		source_id = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(13'd4096, 4'd10);
		send_word(make_word(16'hFFFF, 1'b0, 11'd0, 16'd0));      // stray while idle
		send_word(make_word(16'h0000, 1'b1, 11'd3, 16'hFFFF));   // bad source wins over short
		send_word(make_word(16'hFFFF, 1'b1, 11'h7FF, 16'd9));    // padding too long
		send_word(make_word(16'h0000, 1'b1, 11'd5, 16'd4));      // too short
		// clean bank, last data word also closes it
		send_word(make_word(16'h0000, 1'b1, 11'd9, 16'd6));
		send_word(make_word(16'h0000, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd2, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'h0FFF, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'hF000, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd0, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd0, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd1, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'h5123, 1'b0, 11'd0, 16'd0));
		// bank ends inside a section, hit then error on the last word
		send_word(make_word(16'h0000, 1'b1, 11'd6, 16'd8));
		send_word(make_word(16'h0000, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd0, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd2, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'h1001, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'h2002, 1'b0, 11'd0, 16'd0));
		// oversized length, dropped by a restart
		send_word(make_word(16'h0000, 1'b1, 11'h7FF, 16'd2));
		send_word(make_word(16'h0000, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'd3, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'hA000, 1'b0, 11'd0, 16'd0));
		// count overrun, then a word that must be ignored
		send_word(make_word(16'h0000, 1'b1, 11'd6, 16'd5));
		send_word(make_word(16'h0000, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'hFFFF, 1'b0, 11'd0, 16'd0));
		send_word(make_word(16'h1234, 1'b0, 11'd0, 16'd0));

		set_config(13'd4096, 4'd0);
		run_random(30);
		set_config(13'd0, 4'd10);
		run_random(200);
		set_config(13'd1, 4'd1);
		run_random(200);
		set_config(13'($urandom_range(0, 4096)), 4'($urandom_range(0, 10)));
		run_random(220);
		set_config(13'd4095, 4'd9);
		run_random(220);
		set_config(13'($urandom_range(0, 4096)), 4'($urandom_range(0, 10)));
		run_random(220);
		set_config(13'd2048, 4'd10);
		run_random(220);

		push <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		sb.report_leftover();
		if (sb.failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

>>> sim.f
+incdir+rtl
rtl/drbhp_pkg.sv
rtl/drbhp_front.sv
rtl/drbhp_queue.sv
rtl/drbhp_back.sv
rtl/detector_raw_bank_hit_parser.sv
test/detector_raw_bank_hit_parser_tb.sv
